@@ rtl/ptfp_pkg.sv @@
// Package for the phase table frame packer: widths, frame codes, the
// command record passed from front to back, and the back-end stage type.
// No dependencies.
package ptfp_pkg;

   localparam int PHASE_W     = 9;
   localparam int DUTY_W      = 9;
   localparam int PAIR_W      = PHASE_W + DUTY_W;
   localparam int BYTE_W      = 8;
   localparam int SUM_W       = 16;
   localparam int CHAN_W      = 6;
   localparam int HOLD_DEPTH  = 3;
   localparam int GROUP_BYTES = 9;
   localparam int IDX_W       = 5;
   localparam int CMDQ_DEPTH  = 4;

   localparam logic [CHAN_W-1:0] LAST_CHANNEL = CHAN_W'(55);
   localparam logic [DUTY_W-1:0] DUTY_RESET   = DUTY_W'(256);

   localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hFF;
   localparam logic [BYTE_W-1:0] OPEN_TAG   = 8'hF0;
   localparam logic [BYTE_W-1:0] CLOSE_TAG  = 8'hF1;
   localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h00;

   localparam logic [IDX_W-1:0] CODE_LAST_IDX  = IDX_W'(2);
   localparam logic [IDX_W-1:0] DATA_LAST_IDX  = IDX_W'(GROUP_BYTES - 1);
   localparam logic [IDX_W-1:0] PAD_LAST_IDX   = IDX_W'(17);
   localparam logic [IDX_W-1:0] SUM_LAST_IDX   = IDX_W'(1);

   typedef logic [GROUP_BYTES-1:0][BYTE_W-1:0] word_type;

   typedef struct packed {
      logic     open_frame;
      logic     send_group;
      logic     close_frame;
      word_type word;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HEAD,
      ST_OPEN,
      ST_DATA,
      ST_PAD,
      ST_CLOSE,
      ST_SUM
   } stage_type;

endpackage

@@ rtl/phase_table_frame_packer.sv @@
// Top level of the phase table frame packer: front end, command queue and
// back end. Depends on ptfp_pkg, ptfp_front, ptfp_cmdq and ptfp_back.
//
// Packs 56 channel items (9-bit phase, enable) into one serial byte frame.
// Channel 0 opens the frame with FF FF F0; every fourth channel emits the
// 9 bytes of its group's 72-bit {phase,duty} word, least significant byte
// first; channel 55 adds 18 zero bytes, the close code FF FF F1 and the
// 16-bit sum of the data bytes, high byte first. Duty is latched from the
// duty register when each item is accepted. The front takes one transaction
// per cycle while the command queue has room; the back drives one byte per
// cycle while the output is popped, so throughput is set by the byte output:
// an item causes 0, 3, 9 or 32 bytes, 152 per frame of 56 items, under 3
// bytes per item on average.
module phase_table_frame_packer #(
   parameter int CMDQ_DEPTH = ptfp_pkg::CMDQ_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [ptfp_pkg::PHASE_W-1:0] req_phase,
   input  logic                         req_enable,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [ptfp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_run_last,
   output logic                         rsp_frame_end,
   input  logic                         csr_write_en,
   input  logic [ptfp_pkg::DUTY_W-1:0]  csr_write_data
);
   import ptfp_pkg::*;

   cmd_type push_cmd, head_cmd;
   logic    cmd_push, q_full, q_valid, q_pop;

   // front: accept and classify channel transactions
   ptfp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_phase      (req_phase),
      .req_enable     (req_enable),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_full         (q_full),
      .req_full       (req_full),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   // queue: decouple front stalls from back stalls
   ptfp_cmdq #(
      .DEPTH (CMDQ_DEPTH)
   ) u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .valid    (q_valid),
      .head     (head_cmd),
      .pop      (q_pop)
   );

   // back: serialize each command into frame bytes
   ptfp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (head_cmd),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

@@ rtl/ptfp_front.sv @@
// Front end of the frame packer: takes channel items, holds the first three
// pairs of each group and issues one command per item that produces bytes.
// Depends on ptfp_pkg.
module ptfp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic [ptfp_pkg::PHASE_W-1:0] req_phase,
   input  logic                         req_enable,
   input  logic                         csr_write_en,
   input  logic [ptfp_pkg::DUTY_W-1:0]  csr_write_data,
   input  logic                         q_full,
   output logic                         req_full,
   output logic                         cmd_push,
   output ptfp_pkg::cmd_type            cmd
);
   import ptfp_pkg::*;

   logic [DUTY_W-1:0] duty_ff;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [PAIR_W-1:0] hold_ff [HOLD_DEPTH];
   logic [DUTY_W-1:0] duty;
   logic [PAIR_W-1:0] pair;
   logic              accept;
   logic              is_open, is_group, is_close;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   assign duty     = req_enable ? duty_ff : '0;
   assign pair     = {req_phase, duty};
   assign is_open  = (chan_ff == '0);
   assign is_group = (chan_ff[1:0] == 2'd3);
   assign is_close = (chan_ff == LAST_CHANNEL);
   assign chan_in  = is_close ? '0 : chan_ff + 1'b1;

   always_comb begin
      cmd.open_frame  = is_open;
      cmd.send_group  = is_group;
      cmd.close_frame = is_close;
      cmd.word        = word_type'({pair, hold_ff[2], hold_ff[1], hold_ff[0]});
   end

   assign cmd_push = accept && (is_open || is_group);

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= DUTY_RESET;
         chan_ff <= '0;
      end else begin
         if (csr_write_en) begin
            duty_ff <= csr_write_data;
         end
         if (accept) begin
            chan_ff <= chan_in;
         end
      end
   end

   // hold pairs of the first three channels of a group
   always_ff @(posedge clock) begin
      if (accept) begin
         case (chan_ff[1:0])
            2'd0:    hold_ff[0] <= pair;
            2'd1:    hold_ff[1] <= pair;
            2'd2:    hold_ff[2] <= pair;
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/ptfp_cmdq.sv @@
// Short command queue between front and back of the frame packer.
// Depends on ptfp_pkg.
module ptfp_cmdq #(
   parameter int DEPTH = ptfp_pkg::CMDQ_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptfp_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              valid,
   output ptfp_pkg::cmd_type head,
   input  logic              pop
);
   import ptfp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/ptfp_back.sv @@
// Back end of the frame packer: walks each command byte by byte, keeps the
// running checksum and drives the result output register.
// Depends on ptfp_pkg.
module ptfp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  ptfp_pkg::cmd_type           q_head,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [ptfp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_run_last,
   output logic                        rsp_frame_end
);
   import ptfp_pkg::*;

   stage_type          stage_ff, stage_in, stage_cur;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff, byte_cur;
   logic               out_last_ff, out_end_ff;
   logic               advance, stage_done, cmd_done, frame_done, is_data;
   stage_type          stage_after;

   assign advance   = q_valid && (!out_valid_ff || rsp_pop);
   assign stage_cur = (stage_ff == ST_HEAD) ?
                      (q_head.open_frame ? ST_OPEN : ST_DATA) : stage_ff;

   always_comb begin
      byte_cur    = PAD_BYTE;
      stage_done  = 1'b0;
      stage_after = ST_HEAD;
      cmd_done    = 1'b0;
      frame_done  = 1'b0;
      is_data     = 1'b0;
      unique case (stage_cur)
         ST_OPEN: begin
            byte_cur    = (idx_ff == CODE_LAST_IDX) ? OPEN_TAG : SYNC_BYTE;
            stage_done  = (idx_ff == CODE_LAST_IDX);
            stage_after = q_head.send_group ? ST_DATA : ST_HEAD;
            cmd_done    = stage_done && !q_head.send_group;
         end
         ST_DATA: begin
            byte_cur    = q_head.word[idx_ff[3:0]];
            is_data     = 1'b1;
            stage_done  = (idx_ff == DATA_LAST_IDX);
            stage_after = q_head.close_frame ? ST_PAD : ST_HEAD;
            cmd_done    = stage_done && !q_head.close_frame;
         end
         ST_PAD: begin
            byte_cur    = PAD_BYTE;
            stage_done  = (idx_ff == PAD_LAST_IDX);
            stage_after = ST_CLOSE;
         end
         ST_CLOSE: begin
            byte_cur    = (idx_ff == CODE_LAST_IDX) ? CLOSE_TAG : SYNC_BYTE;
            stage_done  = (idx_ff == CODE_LAST_IDX);
            stage_after = ST_SUM;
         end
         ST_SUM: begin
            byte_cur    = (idx_ff == '0) ? sum_ff[SUM_W-1:BYTE_W] : sum_ff[BYTE_W-1:0];
            stage_done  = (idx_ff == SUM_LAST_IDX);
            stage_after = ST_HEAD;
            cmd_done    = stage_done;
            frame_done  = stage_done;
         end
         default: ;
      endcase
   end

   // next stage, index and checksum
   always_comb begin
      stage_in = stage_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      if (advance) begin
         if (stage_done) begin
            stage_in = stage_after;
            idx_in   = '0;
         end else begin
            stage_in = stage_cur;
            idx_in   = idx_ff + 1'b1;
         end
         if (stage_cur == ST_OPEN || frame_done) begin
            sum_in = '0;
         end else if (is_data) begin
            sum_in = sum_ff + SUM_W'(byte_cur);
         end
      end
   end

   assign q_pop = advance && cmd_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= ST_HEAD;
         idx_ff       <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= byte_cur;
         out_last_ff <= cmd_done;
         out_end_ff  <= frame_done;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_last  = out_last_ff;
   assign rsp_frame_end = out_end_ff;

endmodule
